>>> rtl/core/puvl_pkg.sv
package puvl_pkg;

  localparam int unsigned SlotsDef = 8;
  localparam int unsigned IdW      = 32;
  localparam int unsigned TimeW    = 48;
  localparam int unsigned RangeW   = 21;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned CountW   = 8;
  localparam int unsigned MaskW    = 6;

  typedef enum logic [2:0] {
    ActOpen   = 3'd0,
    ActClose  = 3'd1,
    ActGrant  = 3'd2,
    ActOpp    = 3'd3,
    ActWindow = 3'd4,
    ActQuery  = 3'd5
  } action_e;

  typedef enum logic [2:0] {
    RegEntryDwell = 3'd0,
    RegClearWin   = 3'd1,
    RegClearRange = 3'd2,
    RegClearValid = 3'd3,
    RegOppValid   = 3'd4,
    RegWildcard   = 3'd5
  } reg_e;

  localparam logic [1:0] SideInside  = 2'd1;
  localparam logic [1:0] SideOutside = 2'd2;

  localparam logic [31:0] EntryDwellRst = 32'd60000;
  localparam logic [7:0]  ClearWinRst   = 8'd3;
  localparam logic [19:0] ClearRangeRst = 20'd3000;
  localparam logic [31:0] ClearValidRst = 32'd10000;
  localparam logic [7:0]  CountMax      = 8'hFF;

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StApply,
    StQuery,
    StOut
  } state_e;

  typedef struct packed {
    logic start_scan;
    logic step_scan;
    logic apply;
    logic eval;
  } ctl_t;

  typedef struct packed {
    logic scan_last;
    logic has_result;
  } sts_t;

endpackage

>>> rtl/core/puvl_if.sv
interface puvl_in_if;
  import puvl_pkg::*;
  logic              valid;
  logic              ready;
  logic [2:0]        action;
  logic [IdW-1:0]    cred;
  logic [1:0]        side;
  logic signed [RangeW-1:0] rng_mm;
  logic [TimeW-1:0]  now;
  modport source (output valid, action, cred, side, rng_mm, now, input ready);
  modport sink (input valid, action, cred, side, rng_mm, now, output ready);
endinterface

interface puvl_out_if;
  import puvl_pkg::*;
  logic             valid;
  logic             ready;
  logic             may_unlock;
  logic [MaskW-1:0] veto_mask;
  modport source (output valid, may_unlock, veto_mask, input ready);
  modport sink (input valid, may_unlock, veto_mask, output ready);
endinterface

interface puvl_cfg_if;
  import puvl_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/core/puvl_ctrl.sv
module puvl_ctrl
  import puvl_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  output logic   out_valid_o,
  input  logic   out_ready_i,
  input  sts_t   sts_i,
  output ctl_t   ctl_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (in_valid_i) state_d = StScan;
      StScan:  if (sts_i.scan_last) state_d = StApply;
      StApply: state_d = sts_i.has_result ? StQuery : StIdle;
      StQuery: state_d = StOut;
      StOut:   if (out_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    in_ready_o  = (state_q == StIdle);
    out_valid_o = (state_q == StOut);
    ctl_o.start_scan = (state_q == StIdle) && in_valid_i;
    ctl_o.step_scan  = (state_q == StScan);
    ctl_o.apply      = (state_q == StApply);
    ctl_o.eval       = (state_q == StQuery);
  end

endmodule

>>> rtl/core/puvl_dp.sv
module puvl_dp
  import puvl_pkg::*;
#(
  parameter int unsigned Slots = SlotsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [2:0]               action_i,
  input  logic [IdW-1:0]           cred_i,
  input  logic [1:0]               side_i,
  input  logic signed [RangeW-1:0] rng_mm_i,
  input  logic [TimeW-1:0]         now_i,
  input  logic                     cfg_we_i,
  input  logic [CfgIdxW-1:0]       cfg_idx_i,
  input  logic [CfgDataW-1:0]      cfg_data_i,
  input  ctl_t                     ctl_i,
  output sts_t                     sts_o,
  output logic                     may_unlock_o,
  output logic [MaskW-1:0]         veto_mask_o
);

  localparam int unsigned SW = (Slots > 1) ? $clog2(Slots) : 1;

  logic [31:0] dwell_q, cvalid_q, ovalid_q, wild_q;
  logic [7:0]  cwin_q;
  logic [19:0] crange_q;

  logic [IdW-1:0]   id_q   [Slots];
  logic [TimeW-1:0] in_t_q [Slots];
  logic [TimeW-1:0] op_t_q [Slots];
  logic [Slots-1:0] used_q, opp_q;

  logic             sess_q;
  logic [IdW-1:0]   scred_q;
  logic [CountW-1:0] agree_q;
  logic [TimeW-1:0] lout_q;

  logic [2:0]               act_q;
  logic [IdW-1:0]           cred_q;
  logic [1:0]               side_q;
  logic signed [RangeW-1:0] rng_q;
  logic [TimeW-1:0]         now_q;

  logic [SW-1:0] idx_q;
  logic          hit_q, free_q, vic_ok_q;
  logic [SW-1:0] hit_i_q, free_i_q, vic_q;
  logic          may_q;
  logic [MaskW-1:0] mask_q;

  logic          is_wild;
  logic          tgt_ok;
  logic [SW-1:0] tgt;
  logic          alloc;

  assign is_wild = (cred_q == wild_q);
  assign alloc   = !hit_q;
  assign tgt_ok  = hit_q || free_q || vic_ok_q;
  assign tgt     = hit_q ? hit_i_q : (free_q ? free_i_q : vic_q);

  assign sts_o.scan_last  = (idx_q == SW'(Slots - 1));
  assign sts_o.has_result = (act_q == ActQuery);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dwell_q  <= EntryDwellRst;
      cwin_q   <= ClearWinRst;
      crange_q <= ClearRangeRst;
      cvalid_q <= ClearValidRst;
      ovalid_q <= '0;
      wild_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegEntryDwell: dwell_q  <= cfg_data_i;
        RegClearWin:   cwin_q   <= cfg_data_i[7:0];
        RegClearRange: crange_q <= cfg_data_i[19:0];
        RegClearValid: cvalid_q <= cfg_data_i;
        RegOppValid:   ovalid_q <= cfg_data_i;
        RegWildcard:   wild_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start_scan) begin
      act_q  <= action_i;
      cred_q <= cred_i;
      side_q <= side_i;
      rng_q  <= rng_mm_i;
      now_q  <= now_i;
    end
  end

  // slot walk: find hit, lowest free, oldest-inside victim
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      hit_q    <= 1'b0;
      free_q   <= 1'b0;
      vic_ok_q <= 1'b0;
      hit_i_q  <= '0;
      free_i_q <= '0;
      vic_q    <= '0;
    end else if (ctl_i.start_scan) begin
      idx_q    <= '0;
      hit_q    <= 1'b0;
      free_q   <= 1'b0;
      vic_ok_q <= 1'b0;
    end else if (ctl_i.step_scan) begin
      if (!sts_o.scan_last) idx_q <= idx_q + 1'b1;
      if (used_q[idx_q] && id_q[idx_q] == cred_q && !hit_q) begin
        hit_q   <= 1'b1;
        hit_i_q <= idx_q;
      end
      if (!used_q[idx_q] && !free_q) begin
        free_q   <= 1'b1;
        free_i_q <= idx_q;
      end
      if (used_q[idx_q] && !free_q &&
          (!vic_ok_q || in_t_q[idx_q] < in_t_q[vic_q])) begin
        vic_ok_q <= 1'b1;
        vic_q    <= idx_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.apply) begin
      if ((act_q == ActGrant || act_q == ActOpp) && !is_wild && tgt_ok && alloc) begin
        id_q[tgt] <= cred_q;
      end
      if (!is_wild && tgt_ok && (act_q == ActGrant || (act_q == ActOpp && alloc))) begin
        in_t_q[tgt] <= now_q;
      end
      for (int i = 0; i < Slots; i++) begin
        if ((act_q == ActGrant && !is_wild && tgt_ok && (used_q[i] || i == int'(tgt))) ||
            (act_q == ActOpp && is_wild && used_q[i]) ||
            (act_q == ActOpp && !is_wild && tgt_ok && i == int'(tgt))) begin
          op_t_q[i] <= now_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q  <= '0;
      opp_q   <= '0;
      sess_q  <= 1'b0;
      scred_q <= '0;
      agree_q <= '0;
      lout_q  <= '0;
    end else if (ctl_i.apply) begin
      case (act_q)
        ActOpen: begin
          sess_q  <= 1'b1;
          scred_q <= cred_q;
          agree_q <= '0;
          lout_q  <= '0;
        end
        ActClose: begin
          sess_q  <= 1'b0;
          scred_q <= '0;
          agree_q <= '0;
          lout_q  <= '0;
        end
        ActGrant: begin
          if (!is_wild && tgt_ok) begin
            used_q[tgt] <= 1'b1;
            opp_q       <= used_q | (Slots'(1) << tgt);
            agree_q     <= '0;
            lout_q      <= '0;
          end
        end
        ActOpp: begin
          if (is_wild) begin
            opp_q <= opp_q | used_q;
          end else if (tgt_ok) begin
            used_q[tgt] <= 1'b1;
            opp_q[tgt]  <= 1'b1;
          end
        end
        ActWindow: begin
          if (sess_q && scred_q == cred_q) begin
            if (side_q == SideInside) begin
              agree_q <= '0;
              lout_q  <= '0;
            end else if (side_q == SideOutside) begin
              if (agree_q != '0 ||
                  (!rng_q[RangeW-1] && rng_q[RangeW-2:0] >= crange_q)) begin
                if (agree_q != CountMax) agree_q <= agree_q + 1'b1;
                lout_q <= now_q;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // query evaluated from scan results (state unchanged by a query)
  logic signed [TimeW:0] d_opp, d_in, d_out;
  logic [MaskW-1:0] why;
  always_comb begin
    d_opp = $signed({1'b0, now_q}) - $signed({1'b0, op_t_q[hit_i_q]});
    d_in  = $signed({1'b0, now_q}) - $signed({1'b0, in_t_q[hit_i_q]});
    d_out = $signed({1'b0, now_q}) - $signed({1'b0, lout_q});
    why = '0;
    why[0] = !sess_q || scred_q != cred_q || is_wild;
    if (!hit_q) begin
      why[1] = 1'b1;
    end else begin
      why[2] = !(opp_q[hit_i_q] && !(ovalid_q != '0 &&
                 d_opp > $signed({17'd0, ovalid_q})));
      why[3] = d_in < $signed({17'd0, dwell_q});
    end
    if (agree_q < cwin_q) why[4] = 1'b1;
    else if (cvalid_q != '0 && d_out > $signed({17'd0, cvalid_q})) why[5] = 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.eval) begin
      mask_q <= why;
      may_q  <= (why == '0);
    end
  end

  assign may_unlock_o = may_q;
  assign veto_mask_o  = mask_q;

endmodule

>>> rtl/core/passive_unlock_veto_latch.sv
// Passive unlock veto latch.
// Channels: in_if (event request: action, cred, side, rng_mm, now),
// out_if (query verdict: may_unlock, veto_mask), cfg_if (register writes,
// index 0..5, taken at any cycle; write only while idle).
// One request at a time: accept, a walk over SLOTS table slots (one slot per
// cycle), then an apply step. After a non-query request the block returns to
// idle and takes the next one. A query adds an evaluate step: its verdict
// then shows on out_if and is held until taken, and only then is the next
// request taken. The slot walk sets the rate.
// Only queries (action 5) produce a verdict; others return none.
// Reset clears the table marks, the session and the registers to defaults.
// A stalled receiver holds the verdict and blocks new requests.
module passive_unlock_veto_latch
  import puvl_pkg::*;
#(
  parameter int unsigned Slots = SlotsDef
) (
  input logic        clk_i,
  input logic        rst_ni,
  puvl_in_if.sink    in_if,
  puvl_out_if.source out_if,
  puvl_cfg_if.sink   cfg_if
);

  ctl_t ctl;
  sts_t sts;

  assign cfg_if.ready = 1'b1;

  puvl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  puvl_dp #(.Slots(Slots)) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .action_i     (in_if.action),
    .cred_i       (in_if.cred),
    .side_i       (in_if.side),
    .rng_mm_i     (in_if.rng_mm),
    .now_i        (in_if.now),
    .cfg_we_i     (cfg_if.valid),
    .cfg_idx_i    (cfg_if.index),
    .cfg_data_i   (cfg_if.data),
    .ctl_i        (ctl),
    .sts_o        (sts),
    .may_unlock_o (out_if.may_unlock),
    .veto_mask_o  (out_if.veto_mask)
  );

endmodule

>>> rtl/core/puvl_chk.sv
module puvl_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       may_unlock_i,
  input logic [5:0] veto_mask_i
);

  a_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (may_unlock_i == (veto_mask_i == 6'd0)))
    else $error("verdict disagrees with mask");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i)
    else $error("request taken while verdict pending");

  a_no_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !out_valid_i)
    else $error("verdict too early");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(veto_mask_i)))
    else $error("stalled verdict changed");

endmodule

bind passive_unlock_veto_latch puvl_chk u_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_if.valid),
  .in_ready_i   (in_if.ready),
  .out_valid_i  (out_if.valid),
  .out_ready_i  (out_if.ready),
  .may_unlock_i (out_if.may_unlock),
  .veto_mask_i  (out_if.veto_mask)
);

>>> bench/tb_passive_unlock_veto_latch.sv
module tb_passive_unlock_veto_latch;
  import puvl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSlots = SlotsDef;
  localparam int IdleLimit = 5000;
  localparam logic [2:0] ActSpare6 = 3'd6;
  localparam logic [2:0] ActSpare7 = 3'd7;
  localparam logic [2:0] RegSpare = 3'd6;
  localparam logic [2:0] RegSpareTop = 3'd7;
  localparam logic [1:0] SideUnknown = 2'd0;
  localparam logic [1:0] SideThresh = 2'd3;

  typedef struct {
    logic [2:0] act;
    logic [IdW-1:0] cred;
    logic [1:0] side;
    logic signed [RangeW-1:0] rng;
    logic [TimeW-1:0] now;
  } event_t;

  typedef struct {
    logic ok;
    logic [MaskW-1:0] mask;
  } verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  puvl_in_if in_if();
  puvl_out_if out_if();
  puvl_cfg_if cfg_if();

  passive_unlock_veto_latch i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_if (in_if.sink),
    .out_if(out_if.source),
    .cfg_if(cfg_if.sink)
  );

  always #5 clk_i = ~clk_i;

  event_t pending_events[$];
  verdict_t verdicts_due[$];
  int errors = 0;

  // Shadow of the register set
  logic [31:0] dwell_ms = EntryDwellRst;
  logic [7:0] need_windows = ClearWinRst;
  logic [19:0] min_range = ClearRangeRst;
  logic [31:0] run_valid_ms = ClearValidRst;
  logic [31:0] opp_valid_ms = '0;
  logic [31:0] any_cred = '0;

  // Shadow of the credential table and session
  logic [IdW-1:0] rec_id[NSlots];
  logic [TimeW-1:0] rec_inside[NSlots];
  logic [TimeW-1:0] rec_opp_at[NSlots];
  logic rec_used[NSlots];
  logic rec_opp[NSlots];
  logic sess_on = 1'b0;
  logic [IdW-1:0] sess_cred = '0;
  int agree = 0;
  logic [TimeW-1:0] last_out = '0;

  initial begin
    for (int i = 0; i < NSlots; i++) begin
      rec_id[i] = '0;
      rec_inside[i] = '0;
      rec_opp_at[i] = '0;
      rec_used[i] = 1'b0;
      rec_opp[i] = 1'b0;
    end
  end

  function automatic longint elapsed(logic [TimeW-1:0] now, logic [TimeW-1:0] t);
    return longint'({16'b0, now}) - longint'({16'b0, t});
  endfunction

  function automatic int lookup(logic [IdW-1:0] id);
    for (int i = 0; i < NSlots; i++)
      if (rec_used[i] && rec_id[i] == id) return i;
    return -1;
  endfunction

  function automatic int claim(logic [IdW-1:0] id, logic [TimeW-1:0] now);
    int v;
    v = -1;
    for (int i = 0; i < NSlots; i++) begin
      if (!rec_used[i]) begin
        v = i;
        break;
      end
      if (v < 0 || rec_inside[i] < rec_inside[v]) v = i;
    end
    rec_id[v] = id;
    rec_inside[v] = now;
    rec_opp_at[v] = '0;
    rec_opp[v] = 1'b0;
    rec_used[v] = 1'b1;
    return v;
  endfunction

  function automatic void mark_all_opp(logic [TimeW-1:0] now);
    for (int i = 0; i < NSlots; i++)
      if (rec_used[i]) begin
        rec_opp[i] = 1'b1;
        rec_opp_at[i] = now;
      end
  endfunction

  function automatic void apply_event(event_t e);
    int r;
    logic [5:0] why;
    logic have;
    verdict_t v;
    case (e.act) inside
      ActOpen, ActClose: begin
        sess_on = (e.act == ActOpen);
        sess_cred = (e.act == ActOpen) ? e.cred : '0;
        agree = 0;
        last_out = '0;
      end
      ActGrant: begin
        if (e.cred != any_cred) begin
          r = lookup(e.cred);
          if (r < 0) r = claim(e.cred, e.now);
          mark_all_opp(e.now);
          rec_inside[r] = e.now;
          agree = 0;
          last_out = '0;
        end
      end
      ActOpp: begin
        if (e.cred == any_cred) begin
          mark_all_opp(e.now);
        end else begin
          r = lookup(e.cred);
          if (r < 0) r = claim(e.cred, e.now);
          rec_opp[r] = 1'b1;
          rec_opp_at[r] = e.now;
        end
      end
      ActWindow: begin
        if (sess_on && sess_cred == e.cred) begin
          if (e.side == SideInside) begin
            agree = 0;
            last_out = '0;
          end else if (e.side == SideOutside &&
                       !(agree == 0 && int'(e.rng) < int'({12'b0, min_range}))) begin
            if (agree < int'(CountMax)) agree++;
            last_out = e.now;
          end
        end
      end
      ActQuery: begin
        why = '0;
        if (!sess_on || sess_cred != e.cred || e.cred == any_cred) why[0] = 1'b1;
        r = lookup(e.cred);
        if (r < 0) begin
          why[1] = 1'b1;
        end else begin
          have = rec_opp[r];
          if (have && opp_valid_ms != 0 &&
              elapsed(e.now, rec_opp_at[r]) > longint'({32'b0, opp_valid_ms}))
            have = 1'b0;
          if (!have) why[2] = 1'b1;
          if (elapsed(e.now, rec_inside[r]) < longint'({32'b0, dwell_ms})) why[3] = 1'b1;
        end
        if (agree < int'(need_windows)) why[4] = 1'b1;
        else if (run_valid_ms != 0 &&
                 elapsed(e.now, last_out) > longint'({32'b0, run_valid_ms}))
          why[5] = 1'b1;
        v.ok = (why == 0);
        v.mask = why;
        verdicts_due.push_back(v);
      end
      default: ;
    endcase
  endfunction

  // Request driver: bursts with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    event_t e;
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.action <= '0;
      in_if.cred <= '0;
      in_if.side <= '0;
      in_if.rng_mm <= '0;
      in_if.now <= '0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        e.act = in_if.action;
        e.cred = in_if.cred;
        e.side = in_if.side;
        e.rng = in_if.rng_mm;
        e.now = in_if.now;
        apply_event(e);
      end
      if (!in_if.valid || in_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_if.valid <= 1'b0;
        end else if (pending_events.size() > 0) begin
          e = pending_events.pop_front();
          in_if.valid <= 1'b1;
          in_if.action <= e.act;
          in_if.cred <= e.cred;
          in_if.side <= e.side;
          in_if.rng_mm <= e.rng;
          in_if.now <= e.now;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Verdict monitor with its own stall pattern
  int out_cycle = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t v;
    int mode;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (verdicts_due.size() == 0) begin
          $display("%0t: unexpected verdict may_unlock=%0b veto_mask=%02h",
                   $realtime, out_if.may_unlock, out_if.veto_mask);
          errors++;
        end else begin
          v = verdicts_due.pop_front();
          if (out_if.may_unlock !== v.ok) begin
            $display("%0t: may_unlock expected %0b actual %0b",
                     $realtime, v.ok, out_if.may_unlock);
            errors++;
          end
          if (out_if.veto_mask !== v.mask) begin
            $display("%0t: veto_mask expected %02h actual %02h",
                     $realtime, v.mask, out_if.veto_mask);
            errors++;
          end
        end
      end
      out_cycle++;
      mode = (out_cycle / 400) % 3;
      case (mode)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= ($urandom_range(0, 3) != 0);
        default: out_if.ready <= ((out_cycle % 7) < 3);
      endcase
    end
  end

  // Watchdog on handshake activity
  int quiet = 0;
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet > IdleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  logic [TimeW-1:0] clock_ms = '0;
  logic [IdW-1:0] cred_pool[12];

  task automatic queue_event(logic [2:0] act, logic [IdW-1:0] cred, logic [1:0] side,
                             logic signed [RangeW-1:0] rng, logic [TimeW-1:0] now);
    event_t e;
    e.act = act;
    e.cred = cred;
    e.side = side;
    e.rng = rng;
    e.now = now;
    pending_events.push_back(e);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [31:0] data);
    cfg_if.index <= idx;
    cfg_if.data <= data;
    cfg_if.valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      RegEntryDwell: dwell_ms = data;
      RegClearWin: need_windows = data[7:0];
      RegClearRange: min_range = data[19:0];
      RegClearValid: run_valid_ms = data;
      RegOppValid: opp_valid_ms = data;
      RegWildcard: any_cred = data;
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_events.size() > 0 || in_if.valid || verdicts_due.size() > 0)
      @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic configure(logic [31:0] dw, logic [7:0] cw, logic [19:0] cr,
                           logic [31:0] cv, logic [31:0] ov, logic [31:0] wc);
    cfg_write(RegEntryDwell, dw);
    cfg_write(RegClearWin, {24'b0, cw});
    cfg_write(RegClearRange, {12'b0, cr});
    cfg_write(RegClearValid, cv);
    cfg_write(RegOppValid, ov);
    cfg_write(RegWildcard, wc);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic logic signed [RangeW-1:0] pick_range();
    int r;
    case ($urandom_range(0, 5))
      0: return -21'sd1;
      1: return RangeW'($urandom);
      2: return $signed({1'b0, min_range});
      3: begin
        r = int'(min_range) - $urandom_range(1, 50);
        return (r < 0) ? -21'sd1 : RangeW'(r);
      end
      default: begin
        r = int'(min_range) + $urandom_range(0, 4000);
        return (r > 1048575) ? 21'sd1048575 : RangeW'(r);
      end
    endcase
  endfunction

  task automatic advance_time();
    case ($urandom_range(0, 19))
      0: clock_ms = clock_ms - $urandom_range(0, 5000);
      1: clock_ms = clock_ms + TimeW'({$urandom, $urandom});
      2: clock_ms = clock_ms + $urandom_range(50000, 200000);
      default: clock_ms = clock_ms + $urandom_range(0, 15000);
    endcase
  endtask

  // One unlock approach for a credential, with random content
  task automatic queue_approach();
    logic [IdW-1:0] c;
    int n;
    c = cred_pool[$urandom_range(0, 11)];
    if ($urandom_range(0, 9) == 0) c = any_cred;
    if ($urandom_range(0, 3) != 0)
      queue_event(ActOpen, c, 2'($urandom), RangeW'($urandom), clock_ms);
    if ($urandom_range(0, 3) != 0)
      queue_event(ActGrant, c, 2'($urandom), RangeW'($urandom), clock_ms);
    else if ($urandom_range(0, 1) == 0)
      queue_event(ActOpp, ($urandom_range(0, 2) == 0) ? any_cred : c, 2'($urandom),
                  RangeW'($urandom), clock_ms);
    n = $urandom_range(0, 6);
    for (int k = 0; k < n; k++) begin
      advance_time();
      case ($urandom_range(0, 9))
        0: queue_event(ActWindow, c, SideInside, pick_range(), clock_ms);
        1: queue_event(ActWindow, c, $urandom_range(0, 1) ? SideUnknown : SideThresh,
                       pick_range(), clock_ms);
        2: queue_event(ActWindow, cred_pool[$urandom_range(0, 11)], SideOutside,
                       pick_range(), clock_ms);
        default: queue_event(ActWindow, c, SideOutside, pick_range(), clock_ms);
      endcase
    end
    advance_time();
    queue_event(ActQuery, c, 2'($urandom), RangeW'($urandom), clock_ms);
    if ($urandom_range(0, 4) == 0)
      queue_event(ActClose, c, 2'($urandom), RangeW'($urandom), clock_ms);
  endtask

  task automatic queue_noise();
    logic [IdW-1:0] c;
    c = ($urandom_range(0, 1) == 0) ? cred_pool[$urandom_range(0, 11)] : $urandom;
    queue_event(3'($urandom), c, 2'($urandom), RangeW'($urandom),
                TimeW'({$urandom, $urandom}));
  endtask

  task automatic run_phase(int count);
    int start;
    start = pending_events.size();
    clock_ms = TimeW'({$urandom_range(0, 255), $urandom});
    while (pending_events.size() - start < count) begin
      if ($urandom_range(0, 3) != 0) queue_approach();
      else queue_noise();
    end
    drain();
  endtask

  initial begin
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    for (int i = 0; i < 12; i++) cred_pool[i] = (i < 9) ? i + 1 : $urandom;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset settings
    queue_event(ActQuery, 32'd5, SideUnknown, 21'sd0, 48'd0);
    queue_event(ActOpen, 32'd5, SideUnknown, 21'sd0, 48'd10);
    queue_event(ActGrant, 32'd5, SideUnknown, 21'sd0, 48'd100);
    queue_event(ActGrant, 32'd0, SideUnknown, 21'sd0, 48'd110);
    queue_event(ActWindow, 32'd5, SideOutside, 21'sd2999, 48'd200);
    queue_event(ActWindow, 32'd5, SideOutside, -21'sd1, 48'd210);
    queue_event(ActWindow, 32'd5, SideOutside, 21'sd3000, 48'd300);
    queue_event(ActWindow, 32'd5, SideOutside, 21'sd10, 48'd400);
    queue_event(ActWindow, 32'd6, SideOutside, 21'sd5000, 48'd450);
    queue_event(ActWindow, 32'd5, SideThresh, 21'sd5000, 48'd460);
    queue_event(ActWindow, 32'd5, SideUnknown, 21'sd5000, 48'd470);
    queue_event(ActWindow, 32'd5, SideOutside, 21'sd1048575, 48'd60000);
    queue_event(ActQuery, 32'd5, SideUnknown, 21'sd0, 48'd60100);
    queue_event(ActQuery, 32'd5, SideUnknown, 21'sd0, 48'd50);
    queue_event(ActQuery, 32'd5, SideUnknown, 21'sd0, 48'hFFFF_FFFF_FFFF);
    queue_event(ActWindow, 32'd5, SideInside, 21'sd0, 48'd60200);
    queue_event(ActOpp, 32'd0, SideUnknown, 21'sd0, 48'd60300);
    queue_event(ActSpare6, 32'hFFFF_FFFF, 2'd3, 21'sh10_0000, 48'hFFFF_FFFF_FFFF);
    queue_event(ActSpare7, 32'd5, SideUnknown, 21'sd0, 48'd0);
    for (int i = 1; i <= 9; i++) queue_event(ActOpp, i + 10, SideUnknown, 21'sd0, 48'd1000 - i);
    queue_event(ActQuery, 32'd11, SideUnknown, 21'sd0, 48'd70000);
    queue_event(ActClose, 32'd5, SideUnknown, 21'sd0, 48'd70100);
    queue_event(ActQuery, 32'd0, SideUnknown, 21'sd0, 48'd70200);
    drain();

    run_phase(200);
    configure(32'd0, 8'd0, 20'd0, 32'd0, 32'd0, 32'hFFFF_FFFF);
    run_phase(200);
    configure(32'hFFFF_FFFF, 8'd255, 20'hFFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd3);
    run_phase(150);
    configure(32'd500, 8'd1, 20'd100, 32'd20000, 32'd5000, 32'd7);
    run_phase(250);
    configure(32'd5000, 8'd2, 20'd2000, 32'd1, 32'd1, 32'd0);
    cfg_write(RegSpare, 32'hFFFF_FFFF);
    cfg_write(RegSpareTop, 32'h1234_5678);
    cfg_if.valid <= 1'b0;
    run_phase(250);
    configure(32'd1000, 8'd4, 20'd1500, 32'd0, 32'd30000, 32'd9);
    run_phase(250);
    configure(32'd0, 8'd3, 20'd3000, 32'd10000, 32'd0, 32'hDEAD_BEEF);
    run_phase(300);

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
